>>> design/hsvsea_pkg.sv
// shared constants and types of the hsv saturation / exposure adjust block
// no dependencies; used by the divider pipe and the top level
`timescale 1ns / 1ps

package hsvsea_pkg;

    localparam int CHANNEL_BITS       = 8;
    localparam int GAIN_BITS          = 16;
    localparam int GAIN_FRAC_BITS_DEF = 12;
    localparam int HUE_FRAC_BITS      = 12;
    localparam int SAT_FRAC_BITS      = 16;
    localparam int QUO_BITS           = 16;
    localparam int CFG_INDEX_BITS     = 2;

    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd4096;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SATURATION_GAIN = 2'd0,
        REG_EXPOSURE_GAIN   = 2'd1
    } cfg_reg_t;

    // hue sectors, in sixths of a turn
    typedef enum logic [2:0] {
        SEC_RED_YELLOW    = 3'd0,
        SEC_YELLOW_GREEN  = 3'd1,
        SEC_GREEN_CYAN    = 3'd2,
        SEC_CYAN_BLUE     = 3'd3,
        SEC_BLUE_MAGENTA  = 3'd4,
        SEC_MAGENTA_RED   = 3'd5
    } sector_t;

endpackage

>>> design/hsvsea_div_pipe.sv
// pipelined restoring divider, one quotient bit per register stage
// depends on hsvsea_pkg for the default denominator and quotient widths
`timescale 1ns / 1ps

module hsvsea_div_pipe #(
    parameter int DEN_W = hsvsea_pkg::CHANNEL_BITS,
    parameter int QUO_W = hsvsea_pkg::QUO_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_vld,
    input  logic [DEN_W+QUO_W-1:0] num,
    input  logic [DEN_W-1:0]       den,
    output logic                   out_vld,
    output logic [QUO_W-1:0]       quo
);

    localparam int REM_W = DEN_W + QUO_W;

    logic [REM_W-1:0] rem_reg [0:QUO_W];
    logic [DEN_W-1:0] den_reg [0:QUO_W];
    logic [QUO_W-1:0] quo_reg [0:QUO_W];
    logic             vld_reg [0:QUO_W];

    // load stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= num;
        den_reg[0] <= den;
        quo_reg[0] <= '0;
    end

    // stage st resolves quotient bit QUO_W-st
    for (genvar st = 1; st <= QUO_W; st++)
    begin : g_stage
        logic [REM_W-1:0] trial;
        logic             fits;
        logic [REM_W-1:0] rem_next;
        logic [QUO_W-1:0] quo_next;

        always_comb
        begin
            trial    = REM_W'(den_reg[st-1]) << (QUO_W - st);
            fits     = (rem_reg[st-1] >= trial);
            rem_next = fits ? (rem_reg[st-1] - trial) : rem_reg[st-1];
            quo_next = quo_reg[st-1];
            quo_next[QUO_W-st] = fits;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[st] <= 1'b0;
            end
            else
            begin
                vld_reg[st] <= vld_reg[st-1];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[st] <= rem_next;
            den_reg[st] <= den_reg[st-1];
            quo_reg[st] <= quo_next;
        end
    end

    assign out_vld = vld_reg[QUO_W];
    assign quo     = quo_reg[QUO_W];

endmodule

>>> design/hsv_saturation_exposure_adjust.sv
// top level: rgb to hsv, saturation and exposure gain, hsv back to rgb
// depends on hsvsea_pkg and hsvsea_div_pipe
`timescale 1ns / 1ps

// One pixel is taken at every clock edge where start is high; busy is always low,
// so pixels may come back to back with no gaps. Each pixel passes in order the input,
// chroma, operand, divider, hue, factor, scaling and result registers, with done high for exactly
// one cycle; the receiver cannot stall, so results must be taken when shown.
// The two pipelined dividers (hue fraction and saturation ratio) each resolve one
// quotient bit per stage. Gains are written through the cfg port (always ready);
// write them only while no pixel is in flight.

module hsv_saturation_exposure_adjust #(
    parameter int GAIN_FRAC_BITS = hsvsea_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [hsvsea_pkg::CHANNEL_BITS-1:0]  red_in,
    input  logic [hsvsea_pkg::CHANNEL_BITS-1:0]  green_in,
    input  logic [hsvsea_pkg::CHANNEL_BITS-1:0]  blue_in,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [hsvsea_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [hsvsea_pkg::GAIN_BITS-1:0]     cfg_data,
    output logic                                 done,
    output logic [hsvsea_pkg::CHANNEL_BITS-1:0]  red_out,
    output logic [hsvsea_pkg::CHANNEL_BITS-1:0]  green_out,
    output logic [hsvsea_pkg::CHANNEL_BITS-1:0]  blue_out
);

    import hsvsea_pkg::*;

    localparam int CB      = CHANNEL_BITS;
    localparam int VQ_W    = CB + GAIN_FRAC_BITS;
    localparam int GP_W    = CB + GAIN_BITS;
    localparam int DIV_W   = CB + QUO_BITS;
    localparam int SNUM_W  = GP_W + SAT_FRAC_BITS - GAIN_FRAC_BITS;
    localparam int HNUM_W  = CB + HUE_FRAC_BITS + 1;
    localparam int HQ_W    = HUE_FRAC_BITS + 1;
    localparam int H_W     = HUE_FRAC_BITS + 3;
    localparam int S_W     = SAT_FRAC_BITS + 1;
    localparam int PROD_W  = VQ_W + S_W;
    localparam int RND_SH  = GAIN_FRAC_BITS + SAT_FRAC_BITS;
    localparam int SHR_W   = PROD_W + 1 - RND_SH;
    localparam int LAT     = QUO_BITS + 8;

    localparam logic [CB-1:0]            CH_MAX  = '1;
    localparam logic [S_W-1:0]           S_ONE   = S_W'(1) << SAT_FRAC_BITS;
    localparam logic [HQ_W-1:0]          HUE_ONE = HQ_W'(1) << HUE_FRAC_BITS;
    localparam logic [VQ_W-1:0]          VQ_MAX  = VQ_W'(CH_MAX) << GAIN_FRAC_BITS;
    localparam logic [PROD_W:0]          RND_HALF = (PROD_W+1)'(1) << (RND_SH - 1);

    typedef struct packed {
        sector_t         base;
        logic            neg;
        logic            dz;
        logic            clamp;
        logic [VQ_W-1:0] vq;
    } side_t;

    // round half up, drop fraction bits, saturate at channel max
    function automatic logic [CB-1:0] round_clamp(input logic [PROD_W-1:0] prod);
        logic [PROD_W:0]  rnd;
        logic [SHR_W-1:0] shr;
        rnd = {1'b0, prod} + RND_HALF;
        shr = SHR_W'(rnd >> RND_SH);
        return (shr > SHR_W'(CH_MAX)) ? CH_MAX : shr[CB-1:0];
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [GAIN_BITS-1:0] sat_gain_reg;
    logic [GAIN_BITS-1:0] exp_gain_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;   // fully pipelined, never refuses a pixel

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_gain_reg <= GAIN_RESET;
            exp_gain_reg <= GAIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SATURATION_GAIN: sat_gain_reg <= cfg_data;
                REG_EXPOSURE_GAIN:   exp_gain_reg <= cfg_data;
                default:             ;   // unknown index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage 1: input beat
    // ------------------------------------------------------------------
    logic          s1_vld_reg;
    logic [CB-1:0] s1_r_reg, s1_g_reg, s1_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_r_reg <= red_in;
        s1_g_reg <= green_in;
        s1_b_reg <= blue_in;
    end

    // ------------------------------------------------------------------
    // stage 2: max, min, chroma and the hue sector operands
    // ------------------------------------------------------------------
    logic [CB-1:0] cmax, cmin, plus_c, minus_c;
    sector_t       base_c;

    always_comb
    begin
        cmax = s1_r_reg;
        cmin = s1_r_reg;
        if (s1_g_reg > cmax) cmax = s1_g_reg;
        if (s1_b_reg > cmax) cmax = s1_b_reg;
        if (s1_g_reg < cmin) cmin = s1_g_reg;
        if (s1_b_reg < cmin) cmin = s1_b_reg;
        // ties on the maximum: red wins, then green
        if (cmax == s1_r_reg)
        begin
            base_c  = SEC_RED_YELLOW;
            plus_c  = s1_g_reg;
            minus_c = s1_b_reg;
        end
        else if (cmax == s1_g_reg)
        begin
            base_c  = SEC_GREEN_CYAN;
            plus_c  = s1_b_reg;
            minus_c = s1_r_reg;
        end
        else
        begin
            base_c  = SEC_BLUE_MAGENTA;
            plus_c  = s1_r_reg;
            minus_c = s1_g_reg;
        end
    end

    logic          s2_vld_reg;
    logic [CB-1:0] s2_cmax_reg, s2_d_reg, s2_diff_reg;
    sector_t       s2_base_reg;
    logic          s2_neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_cmax_reg <= cmax;
        s2_d_reg    <= cmax - cmin;
        s2_base_reg <= base_c;
        s2_neg_reg  <= (plus_c < minus_c);
        s2_diff_reg <= (plus_c < minus_c) ? (minus_c - plus_c) : (plus_c - minus_c);
    end

    // ------------------------------------------------------------------
    // stage 3: divider operands, saturation clamp test, scaled value
    // ------------------------------------------------------------------
    logic [HNUM_W-1:0] hue_num;
    logic [GP_W-1:0]   sat_prod;
    logic [SNUM_W-1:0] sat_num;
    logic [GP_W-1:0]   vq_full;
    logic [VQ_W-1:0]   vq_c;
    logic              clamp_c;

    always_comb
    begin
        // a negative offset is rounded toward minus infinity: add d-1 before dividing
        hue_num = (HNUM_W'(s2_diff_reg) << HUE_FRAC_BITS)
                + (s2_neg_reg ? HNUM_W'(s2_d_reg - 1'b1) : HNUM_W'(0));
        sat_prod = GP_W'(s2_d_reg) * GP_W'(sat_gain_reg);
        sat_num  = SNUM_W'(sat_prod) << (SAT_FRAC_BITS - GAIN_FRAC_BITS);
        // ratio at or above one saturates; also keeps a truncated numerator harmless
        clamp_c  = (s2_d_reg != '0)
                && (sat_num >= (SNUM_W'(s2_cmax_reg) << SAT_FRAC_BITS));
        vq_full  = GP_W'(s2_cmax_reg) * GP_W'(exp_gain_reg);
        vq_c     = (vq_full > GP_W'(VQ_MAX)) ? VQ_MAX : vq_full[VQ_W-1:0];
    end

    logic              s3_vld_reg;
    logic [DIV_W-1:0]  s3_hnum_reg, s3_snum_reg;
    logic [CB-1:0]     s3_d_reg, s3_cmax_reg;
    side_t             s3_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_hnum_reg       <= DIV_W'(hue_num);
        s3_snum_reg       <= sat_num[DIV_W-1:0];
        s3_d_reg          <= s2_d_reg;
        s3_cmax_reg       <= s2_cmax_reg;
        s3_side_reg.base  <= s2_base_reg;
        s3_side_reg.neg   <= s2_neg_reg;
        s3_side_reg.dz    <= (s2_d_reg == '0);
        s3_side_reg.clamp <= clamp_c;
        s3_side_reg.vq    <= vq_c;
    end

    // ------------------------------------------------------------------
    // stage 4: the two dividers, side data delayed alongside
    // ------------------------------------------------------------------
    logic                hue_vld, sat_vld;
    logic [QUO_BITS-1:0] hue_quo, sat_quo;

    hsvsea_div_pipe #(
        .DEN_W (CB),
        .QUO_W (QUO_BITS)
    ) u_hue_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (s3_vld_reg),
        .num     (s3_hnum_reg),
        .den     (s3_d_reg),
        .out_vld (hue_vld),
        .quo     (hue_quo)
    );

    hsvsea_div_pipe #(
        .DEN_W (CB),
        .QUO_W (QUO_BITS)
    ) u_sat_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (s3_vld_reg),
        .num     (s3_snum_reg),
        .den     (s3_cmax_reg),
        .out_vld (sat_vld),
        .quo     (sat_quo)
    );

    side_t side_dly_reg [0:QUO_BITS];

    always_ff @(posedge clk)
    begin
        side_dly_reg[0] <= s3_side_reg;
        for (int i = 1; i <= QUO_BITS; i++)
        begin
            side_dly_reg[i] <= side_dly_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // stage 5: hue in sixths, sector and fraction, final saturation
    // ------------------------------------------------------------------
    side_t          sd;
    logic [H_W-1:0] hue_q, hue_start, hue;
    sector_t        sector_c;
    logic [S_W-1:0] s_c;

    always_comb
    begin
        sd    = side_dly_reg[QUO_BITS];
        hue_q = H_W'(hue_quo[HQ_W-1:0]);
        if (!sd.neg)
        begin
            hue_start = {sd.base, {HUE_FRAC_BITS{1'b0}}};
            hue       = hue_start + hue_q;
        end
        else
        begin
            // red sector going negative wraps to the top of the circle
            hue_start = (sd.base == SEC_RED_YELLOW)
                      ? (H_W'(6) << HUE_FRAC_BITS)
                      : {sd.base, {HUE_FRAC_BITS{1'b0}}};
            hue       = hue_start - hue_q;
        end
        if (hue[H_W-1:HUE_FRAC_BITS] > SEC_MAGENTA_RED)
            sector_c = SEC_MAGENTA_RED;
        else
            sector_c = sector_t'(hue[H_W-1:HUE_FRAC_BITS]);
        if (sd.dz)
            s_c = '0;
        else if (sd.clamp)
            s_c = S_ONE;
        else
            s_c = {1'b0, sat_quo};
    end

    logic                     s5_vld_reg;
    sector_t                  s5_sector_reg;
    logic [HUE_FRAC_BITS-1:0] s5_fr_reg;
    logic [S_W-1:0]           s5_s_reg;
    logic [VQ_W-1:0]          s5_vq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_vld_reg <= 1'b0;
        end
        else
        begin
            s5_vld_reg <= hue_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        s5_sector_reg <= sector_c;
        s5_fr_reg     <= hue[HUE_FRAC_BITS-1:0];
        s5_s_reg      <= s_c;
        s5_vq_reg     <= sd.vq;
    end

    // ------------------------------------------------------------------
    // stage 6: rebuild factors p, q, t
    // ------------------------------------------------------------------
    logic [S_W+HQ_W-1:0] sq_prod, st_prod;

    always_comb
    begin
        sq_prod = (S_W+HQ_W)'(s5_s_reg) * (S_W+HQ_W)'(s5_fr_reg);
        st_prod = (S_W+HQ_W)'(s5_s_reg) * (S_W+HQ_W)'(HUE_ONE - HQ_W'(s5_fr_reg));
    end

    logic            s6_vld_reg;
    sector_t         s6_sector_reg;
    logic [S_W-1:0]  s6_pf_reg, s6_qf_reg, s6_tf_reg;
    logic [VQ_W-1:0] s6_vq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_vld_reg <= 1'b0;
        end
        else
        begin
            s6_vld_reg <= s5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s6_sector_reg <= s5_sector_reg;
        s6_pf_reg     <= S_ONE - s5_s_reg;
        s6_qf_reg     <= S_ONE - S_W'(sq_prod >> HUE_FRAC_BITS);
        s6_tf_reg     <= S_ONE - S_W'(st_prod >> HUE_FRAC_BITS);
        s6_vq_reg     <= s5_vq_reg;
    end

    // ------------------------------------------------------------------
    // stage 7: sector select and value scaling
    // ------------------------------------------------------------------
    logic [S_W-1:0] fr_r, fr_g, fr_b;

    always_comb
    begin
        case (s6_sector_reg)
            SEC_RED_YELLOW:
            begin
                fr_r = S_ONE;     fr_g = s6_tf_reg; fr_b = s6_pf_reg;
            end
            SEC_YELLOW_GREEN:
            begin
                fr_r = s6_qf_reg; fr_g = S_ONE;     fr_b = s6_pf_reg;
            end
            SEC_GREEN_CYAN:
            begin
                fr_r = s6_pf_reg; fr_g = S_ONE;     fr_b = s6_tf_reg;
            end
            SEC_CYAN_BLUE:
            begin
                fr_r = s6_pf_reg; fr_g = s6_qf_reg; fr_b = S_ONE;
            end
            SEC_BLUE_MAGENTA:
            begin
                fr_r = s6_tf_reg; fr_g = s6_pf_reg; fr_b = S_ONE;
            end
            default:
            begin
                fr_r = S_ONE;     fr_g = s6_pf_reg; fr_b = s6_qf_reg;
            end
        endcase
    end

    logic              s7_vld_reg;
    logic [PROD_W-1:0] s7_r_reg, s7_g_reg, s7_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_vld_reg <= 1'b0;
        end
        else
        begin
            s7_vld_reg <= s6_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s7_r_reg <= PROD_W'(s6_vq_reg) * PROD_W'(fr_r);
        s7_g_reg <= PROD_W'(s6_vq_reg) * PROD_W'(fr_g);
        s7_b_reg <= PROD_W'(s6_vq_reg) * PROD_W'(fr_b);
    end

    // ------------------------------------------------------------------
    // stage 8: round, clamp, result beat
    // ------------------------------------------------------------------
    logic          done_reg;
    logic [CB-1:0] red_reg, green_reg, blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s7_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= round_clamp(s7_r_reg);
        green_reg <= round_clamp(s7_g_reg);
        blue_reg  <= round_clamp(s7_b_reg);
    end

    assign done      = done_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // both dividers must stay in lockstep with the side delay line
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        hue_vld == sat_vld)
        else $error("hue and saturation dividers out of step");

    // every accepted pixel must be followed by a result beat on done at the end of the pipeline
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result beat missing at fixed latency");

    // saturation never exceeds one after the clamp
    a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
        s5_vld_reg |-> (s5_s_reg <= S_ONE))
        else $error("saturation above one");

    // hue quotient never exceeds one full sixth
    a_hue_quo: assert property (@(posedge clk) disable iff (!rst_n)
        (hue_vld && !sd.dz) |-> (hue_quo <= QUO_BITS'(HUE_ONE)))
        else $error("hue fraction above one sector");

endmodule
